// ===== rtl/core/csr_sparse_matrix_engine_top_macros.svh =====
// ---------------------------------------------------------------------------
// csr_sparse_matrix_engine_top_macros.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATRIX_ENGINE_TOP_MACROS_SVH
`define CSR_SPARSE_MATRIX_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define CSME_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CSME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/csme_pkg.sv =====
// ---------------------------------------------------------------------------
// csme_pkg
// constants, codes and helpers for the compressed-row matrix engine
// ---------------------------------------------------------------------------
package csme_pkg;

    localparam int MAX_DIM     = 256;
    localparam int MAX_ENTRIES = 1024;
    localparam int DIM_AW      = $clog2(MAX_DIM);
    localparam int ENT_AW      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ENT_AW + 1;
    localparam int DIMV_W      = DIM_AW + 1;
    localparam int OP_W        = 3;
    localparam int IDX_W       = 8;
    localparam int VAL_W       = 32;
    localparam int ST_W        = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_SET    = 3'd0;
    localparam logic [OP_W-1:0] OP_GET    = 3'd1;
    localparam logic [OP_W-1:0] OP_DEGREE = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd4;
    localparam logic [OP_W-1:0] OP_SCALE  = 3'd5;
    localparam logic [OP_W-1:0] OP_DIVIDE = 3'd6;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd7;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
    localparam logic [ST_W-1:0] ST_DIVZ  = 3'd3;
    localparam logic [ST_W-1:0] ST_ZERO  = 3'd4;

    // clamp a wide signed value to 32 bits
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[VAL_W-1:0];
    endfunction

endpackage

// ===== rtl/core/csr_sparse_matrix_engine_top.sv =====
// ---------------------------------------------------------------------------
// csr_sparse_matrix_engine_top
// compressed-row sparse matrix store with a dense vector and a row dot product
// ---------------------------------------------------------------------------
// channel    direction  handshake            payload
// command    in         start & !busy        i_op i_row i_col i_value
// result     out        o_valid (one cycle)  o_status o_result_value o_count o_found
//
// degree reads the row bounds; get scans the row entry by entry, a row product
// multiplies and accumulates each entry; insert scans the row, shifts later entries up
// and bumps every row end from its row up; scale reads, multiplies and writes each
// entry, and divide runs the bit-serial divider for 48 steps on each entry.
// every operation is carried out by one sequencer; each memory has one read and one write port.
// reset is synchronous and clears the matrix and vector; the result cannot be stalled.
// ---------------------------------------------------------------------------
module csr_sparse_matrix_engine_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [csme_pkg::OP_W-1:0]             i_op,
    input  logic [csme_pkg::IDX_W-1:0]            i_row,
    input  logic [csme_pkg::IDX_W-1:0]            i_col,
    input  logic signed [csme_pkg::VAL_W-1:0]     i_value,
    output logic                                  o_valid,
    output logic [csme_pkg::ST_W-1:0]             o_status,
    output logic signed [csme_pkg::VAL_W-1:0]     o_result_value,
    output logic [csme_pkg::CNT_W-1:0]            o_count,
    output logic                                  o_found
);
    import csme_pkg::*;

    localparam int EW = IDX_W + VAL_W;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_RS_A, S_RS_B, S_RS_C, S_SCAN_RD, S_SCAN_CHK,
        S_MUL_A, S_MUL_B, S_SH_RD, S_SH_WR, S_RU_RD, S_RU_WR,
        S_SC_RD, S_SC_MUL, S_SC_WR, S_DV_RD, S_DV_INIT, S_DV_STEP, S_DV_WR
    } t_state;

    t_state                   r_state;
    logic [OP_W-1:0]          r_op;
    logic [IDX_W-1:0]         r_row;
    logic [IDX_W-1:0]         r_col;
    logic signed [VAL_W-1:0]  r_val;
    logic [DIMV_W-1:0]        r_dim;
    logic [CNT_W-1:0]         r_total;
    logic [CNT_W-1:0]         r_beg;
    logic [CNT_W-1:0]         r_end;
    logic [CNT_W-1:0]         r_k;
    logic [CNT_W-1:0]         r_pos;
    logic signed [57:0]       r_acc;
    logic signed [VAL_W-1:0]  r_eval;
    logic signed [63:0]       r_prod;
    logic [31:0]              r_rem;
    logic [47:0]              r_quo;
    logic [31:0]              r_dvs;
    logic                     r_neg;
    logic [5:0]               r_cnt;
    logic                     r_ov;
    logic [ST_W-1:0]          r_o_status;
    logic signed [VAL_W-1:0]  r_o_res;
    logic [CNT_W-1:0]         r_o_count;
    logic                     r_o_found;

    // memories, and valid bits for the row-start and vector stores
    logic [CNT_W-1:0]         rs_mem [MAX_DIM];
    logic [MAX_DIM-1:0]       r_rs_vld;
    logic [EW-1:0]            ent_mem [MAX_ENTRIES];
    logic signed [VAL_W-1:0]  dv_mem [MAX_DIM];
    logic [MAX_DIM-1:0]       r_dv_vld;
    logic [CNT_W-1:0]         r_rs_q;
    logic [EW-1:0]            r_ent_q;
    logic signed [VAL_W-1:0]  r_dv_q;

    logic                     rs_we;
    logic [DIM_AW-1:0]        rs_raddr;
    logic [DIM_AW-1:0]        rs_waddr;
    logic [CNT_W-1:0]         rs_wdata;
    logic                     ent_re;
    logic                     ent_we;
    logic [ENT_AW-1:0]        ent_raddr;
    logic [ENT_AW-1:0]        ent_waddr;
    logic [EW-1:0]            ent_wdata;
    logic [DIM_AW-1:0]        dv_raddr;
    logic                     dv_we;
    logic signed [VAL_W-1:0]  mul_a;
    logic signed [VAL_W-1:0]  mul_b;
    logic signed [63:0]       mul_p;

    logic [IDX_W-1:0]         q_col;
    logic signed [VAL_W-1:0]  q_val;
    logic [DIMV_W-1:0]        top;
    logic [32:0]              rem_sh;
    logic                     rem_ge;
    logic signed [63:0]       dq;
    logic signed [VAL_W-1:0]  div_res;
    logic signed [VAL_W-1:0]  sc_res;
    logic [31:0]              abs_e;

    assign q_col   = r_ent_q[EW-1:VAL_W];
    assign q_val   = r_ent_q[VAL_W-1:0];
    assign top     = DIMV_W'((r_row > r_col) ? r_row : r_col) + DIMV_W'(1);
    assign rem_sh  = {r_rem, r_quo[47]};
    assign rem_ge  = rem_sh >= {1'b0, r_dvs};
    assign dq      = r_neg ? -$signed({16'b0, r_quo}) : $signed({16'b0, r_quo});
    assign div_res = sat32(dq);
    assign sc_res  = sat32(r_prod >>> 16);
    assign abs_e   = q_val[VAL_W-1] ? 32'(-q_val) : 32'(q_val);

    // shared multiplier, registered below
    assign mul_p = mul_a * mul_b;

    // memory controls from the sequencer
    always_comb begin
        rs_we     = 1'b0;
        rs_raddr  = r_row;
        rs_waddr  = r_k[DIM_AW-1:0];
        rs_wdata  = r_rs_q + CNT_W'(1);
        ent_re    = 1'b0;
        ent_we    = 1'b0;
        ent_raddr = r_k[ENT_AW-1:0];
        ent_waddr = r_k[ENT_AW-1:0];
        ent_wdata = {r_col, r_val};
        dv_raddr  = q_col;
        dv_we     = 1'b0;
        mul_a     = q_val;
        mul_b     = r_val;
        case (r_state)
            S_DISP: begin
                dv_we = (r_op == OP_LOAD);
            end
            S_RS_A: begin
                rs_raddr = r_row - IDX_W'(1);
            end
            S_SCAN_RD, S_SC_RD, S_DV_RD: begin
                ent_re = (r_state == S_SCAN_RD) ? (r_k < r_end) : (r_k < r_total);
            end
            S_SCAN_CHK: begin
                ent_we = (r_op == OP_SET) && (q_col == r_col);
            end
            S_MUL_A: begin
                mul_a = r_eval;
                mul_b = r_dv_q;
            end
            S_SH_RD: begin
                ent_re    = (r_k > r_pos);
                ent_raddr = ENT_AW'(r_k - CNT_W'(1));
                ent_we    = !(r_k > r_pos);
                ent_waddr = r_pos[ENT_AW-1:0];
            end
            S_SH_WR: begin
                ent_we    = 1'b1;
                ent_wdata = r_ent_q;
            end
            S_RU_RD: begin
                rs_raddr = r_k[DIM_AW-1:0];
            end
            S_RU_WR: begin
                rs_we = 1'b1;
            end
            S_SC_WR: begin
                ent_we    = 1'b1;
                ent_wdata = {q_col, sc_res};
            end
            S_DV_WR: begin
                ent_we    = 1'b1;
                ent_wdata = {q_col, div_res};
            end
            default: begin
            end
        endcase
    end

    // memory arrays, reads registered
    always_ff @(posedge i_clk) begin
        if (rs_we) begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        r_rs_q <= r_rs_vld[rs_raddr] ? rs_mem[rs_raddr] : '0;
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            r_ent_q <= ent_mem[ent_raddr];
        end
        if (dv_we) begin
            dv_mem[r_row] <= r_val;
        end
        r_dv_q <= r_dv_vld[dv_raddr] ? dv_mem[dv_raddr] : '0;
        r_prod <= mul_p;
    end

    // valid bits of the row-start and vector stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_vld <= '0;
            r_dv_vld <= '0;
        end else begin
            if (r_state == S_DISP && r_op == OP_CLEAR) begin
                r_rs_vld <= '0;
            end else if (rs_we) begin
                r_rs_vld[rs_waddr] <= 1'b1;
            end
            if (dv_we) begin
                r_dv_vld[r_row] <= 1'b1;
            end
        end
    end

    // sequencer with registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_dim   <= '0;
            r_total <= '0;
        end else begin
            r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_op;
                        r_row   <= i_row;
                        r_col   <= i_col;
                        r_val   <= i_value;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_acc      <= '0;
                    r_k        <= '0;
                    r_o_status <= ST_OK;
                    r_o_res    <= '0;
                    r_o_found  <= 1'b0;
                    r_o_count  <= r_total;
                    r_state    <= S_RS_A;
                    case (r_op)
                        OP_SET: begin
                            if (r_val == '0) begin
                                r_o_status <= ST_ZERO;
                                r_ov       <= 1'b1;
                                r_state    <= S_IDLE;
                            end else if (12'(r_row) >= 12'(MAX_DIM)
                                         || 12'(r_col) >= 12'(MAX_DIM)) begin
                                r_o_status <= ST_RANGE;
                                r_ov       <= 1'b1;
                                r_state    <= S_IDLE;
                            end
                        end
                        OP_GET: begin
                            if (DIMV_W'(r_row) >= r_dim || DIMV_W'(r_col) >= r_dim) begin
                                r_o_status <= ST_RANGE;
                                r_ov       <= 1'b1;
                                r_state    <= S_IDLE;
                            end
                        end
                        OP_DEGREE, OP_MUL: begin
                            if (DIMV_W'(r_row) >= r_dim) begin
                                r_o_status <= ST_RANGE;
                                r_o_count  <= (r_op == OP_DEGREE) ? '0 : r_total;
                                r_ov       <= 1'b1;
                                r_state    <= S_IDLE;
                            end
                        end
                        OP_LOAD: begin
                            if (12'(r_row) >= 12'(MAX_DIM)) begin
                                r_o_status <= ST_RANGE;
                            end
                            r_ov    <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        OP_SCALE: begin
                            r_state <= S_SC_RD;
                        end
                        OP_DIVIDE: begin
                            if (r_val == '0) begin
                                r_o_status <= ST_DIVZ;
                                r_ov       <= 1'b1;
                                r_state    <= S_IDLE;
                            end else begin
                                r_dvs   <= r_val[VAL_W-1] ? 32'(-r_val) : 32'(r_val);
                                r_state <= S_DV_RD;
                            end
                        end
                        default: begin
                            r_dim     <= '0;
                            r_total   <= '0;
                            r_o_count <= '0;
                            r_ov      <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    endcase
                end
                // fetch row start and row end
                S_RS_A: begin
                    r_state <= S_RS_B;
                end
                S_RS_B: begin
                    r_beg   <= (r_row == '0) ? '0 : r_rs_q;
                    r_state <= S_RS_C;
                end
                S_RS_C: begin
                    r_end <= r_rs_q;
                    r_k   <= r_beg;
                    if (r_op == OP_DEGREE) begin
                        r_o_count <= r_rs_q - r_beg;
                        r_ov      <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_SCAN_RD;
                    end
                end
                // walk the row
                S_SCAN_RD: begin
                    if (r_k < r_end) begin
                        r_state <= S_SCAN_CHK;
                    end else if (r_op == OP_SET) begin
                        if (r_total >= CNT_W'(MAX_ENTRIES)) begin
                            r_o_status <= ST_FULL;
                            r_ov       <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_pos   <= r_k;
                            r_k     <= r_total;
                            r_state <= S_SH_RD;
                        end
                    end else begin
                        if (r_op == OP_MUL) begin
                            r_o_res <= sat32(64'(r_acc));
                        end
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN_CHK: begin
                    r_eval <= q_val;
                    r_k    <= r_k + CNT_W'(1);
                    r_state <= S_SCAN_RD;
                    if (r_op == OP_GET) begin
                        if (q_col == r_col) begin
                            r_o_res   <= q_val;
                            r_o_found <= 1'b1;
                            r_ov      <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    end else if (r_op == OP_SET) begin
                        if (q_col == r_col) begin
                            r_ov    <= 1'b1;
                            r_state <= S_IDLE;
                        end else if (q_col > r_col) begin
                            r_k <= r_k;
                            if (r_total >= CNT_W'(MAX_ENTRIES)) begin
                                r_o_status <= ST_FULL;
                                r_ov       <= 1'b1;
                                r_state    <= S_IDLE;
                            end else begin
                                r_pos   <= r_k;
                                r_k     <= r_total;
                                r_state <= S_SH_RD;
                            end
                        end
                    end else begin
                        r_k     <= r_k;
                        r_state <= S_MUL_A;
                    end
                end
                // row product: multiply then accumulate floor of the product shifted right by 16
                S_MUL_A: begin
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_acc   <= r_acc + 58'(r_prod >>> 16);
                    r_k     <= r_k + CNT_W'(1);
                    r_state <= S_SCAN_RD;
                end
                // open a slot by moving later entries up
                S_SH_RD: begin
                    if (r_k > r_pos) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_k     <= CNT_W'(r_row);
                        r_state <= S_RU_RD;
                    end
                end
                S_SH_WR: begin
                    r_k     <= r_k - CNT_W'(1);
                    r_state <= S_SH_RD;
                end
                // bump the row ends from this row on
                S_RU_RD: begin
                    r_state <= S_RU_WR;
                end
                S_RU_WR: begin
                    if (r_k == CNT_W'(MAX_DIM - 1)) begin
                        r_total   <= r_total + CNT_W'(1);
                        r_o_count <= r_total + CNT_W'(1);
                        if (top > r_dim) begin
                            r_dim <= top;
                        end
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + CNT_W'(1);
                        r_state <= S_RU_RD;
                    end
                end
                // scale every entry
                S_SC_RD: begin
                    if (r_k < r_total) begin
                        r_state <= S_SC_MUL;
                    end else begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SC_MUL: begin
                    r_state <= S_SC_WR;
                end
                S_SC_WR: begin
                    r_k     <= r_k + CNT_W'(1);
                    r_state <= S_SC_RD;
                end
                // divide every entry, one quotient bit a cycle
                S_DV_RD: begin
                    if (r_k < r_total) begin
                        r_state <= S_DV_INIT;
                    end else begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_DV_INIT: begin
                    r_rem   <= '0;
                    r_quo   <= {abs_e, 16'b0};
                    r_neg   <= q_val[VAL_W-1] ^ r_val[VAL_W-1];
                    r_cnt   <= 6'd47;
                    r_state <= S_DV_STEP;
                end
                S_DV_STEP: begin
                    r_rem <= rem_ge ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
                    r_quo <= {r_quo[46:0], rem_ge};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_state <= S_DV_WR;
                    end
                end
                S_DV_WR: begin
                    r_k     <= r_k + CNT_W'(1);
                    r_state <= S_DV_RD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_ov;
    assign o_status       = r_o_status;
    assign o_result_value = r_o_res;
    assign o_count        = r_o_count;
    assign o_found        = r_o_found;

endmodule

// ===== rtl/core/csme_checker.sv =====
// ---------------------------------------------------------------------------
// csme_checker
// port-level checks of the command and result timing
// ---------------------------------------------------------------------------
`include "csr_sparse_matrix_engine_top_macros.svh"

module csme_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [csme_pkg::ST_W-1:0]   o_status,
    input logic                        o_found
);
    import csme_pkg::*;

    // accepted word makes the engine busy
    `CSME_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // a result comes with the engine idle again
    `CSME_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    // results are single-cycle strobes
    `CSME_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    // finishing a word always yields a result
    `CSME_ASSERT_NOW(a_fall_valid, i_clk, i_rst_n, $fell(busy), o_valid)
    // a hit is only reported with ok status
    `CSME_ASSERT_NOW(a_found_ok, i_clk, i_rst_n, o_valid && o_found, o_status == ST_OK)

endmodule

bind csr_sparse_matrix_engine_top csme_checker u_csme_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_found  (o_found)
);
